### rtl/core/spq_pkg.sv
// Shared types and constants for the sorted-array priority queue.
// Used by spq_cell and sorted_array_priority_queue; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int DEPTH   = 8;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 4;

    typedef logic signed [VALUE_W-1:0] t_spq_value;
    typedef logic [CNT_W-1:0]          t_spq_count;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_spq_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_spq_status;

    typedef struct packed {
        t_spq_op    op;
        t_spq_value value;
    } t_spq_in;

    typedef struct packed {
        t_spq_status        status;
        logic [COUNT_W-1:0] entry_count;
        logic               head_valid;
        t_spq_value         head_value;
    } t_spq_out;

    // Command broadcast to every cell.
    typedef struct packed {
        logic       ins;
        logic       del;
        t_spq_value value;
    } t_spq_cmd;

    // Flags rippling from the head cell toward the tail.
    typedef struct packed {
        logic hit;    // insert point at or before this cell
        logic found;  // delete match at or before this cell
    } t_spq_link;

endpackage

`default_nettype wire

### rtl/core/sorted_array_priority_queue.sv
// Top level of the sorted-array priority queue: cell chain, count, result register.
// Depends on spq_pkg and spq_cell.
`timescale 1ns / 1ps
`default_nettype none

// Priority queue of up to DEPTH signed 32-bit values kept in descending order
// in a row of DEPTH cells, largest at cell 0. Each cell compares the request
// value against its own entry and passes an insert-point flag and a
// delete-match flag to the next cell; in the same cycle every cell at or past
// the insert point takes its left neighbor's entry (or the new value), and
// every cell at or past a delete match takes its right neighbor's entry. An
// accepted request therefore updates all cells together, and a new request can be
// taken every cycle: one transfer per clock on the input, limited only by the
// output register being drained. Each request produces exactly one result:
// status (ok, full on insert, empty on delete, not found), the count after the
// operation, and the head value (zero when empty). A full insert or a failed
// delete leaves the contents untouched. The result is registered and shows on
// the output in the cycle after the input transfer.

module sorted_array_priority_queue
    import spq_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_in_valid,
    output logic     o_in_ready,
    input  t_spq_in  i_in_data,
    output logic     o_out_valid,
    input  wire      i_out_ready,
    output t_spq_out o_out_data
);

    t_spq_count  r_count;
    t_spq_count  n_count;
    logic        r_out_valid;
    t_spq_out    r_out;
    t_spq_out    n_out;

    logic        accept;
    logic        is_full;
    logic        is_empty;
    logic        found;
    t_spq_status status;
    t_spq_cmd    cmd;

    t_spq_link   links   [DEPTH+1];
    t_spq_value  entries [DEPTH];
    t_spq_value  nexts   [DEPTH];

    // Take a new request whenever the result register is free or being drained.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);
    assign found    = links[DEPTH].found;

    always_comb begin
        status = ST_OK;
        if (i_in_data.op == OP_INSERT) begin
            if (is_full) begin
                status = ST_FULL;
            end
        end else if (is_empty) begin
            status = ST_EMPTY;
        end else if (!found) begin
            status = ST_NOT_FOUND;
        end
    end

    // Commit to the cells only on a transfer that succeeds.
    always_comb begin
        cmd.ins   = accept && (i_in_data.op == OP_INSERT) && !is_full;
        cmd.del   = accept && (i_in_data.op == OP_DELETE) && found;
        cmd.value = i_in_data.value;
    end

    assign links[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            t_spq_value left_entry;
            t_spq_value right_entry;
            logic       slot_valid;

            assign slot_valid = (CNT_W'(gi) < r_count);

            if (gi == 0) begin : g_head
                assign left_entry = '0;
            end else begin : g_mid_l
                assign left_entry = entries[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign right_entry = '0;
            end else begin : g_mid_r
                assign right_entry = entries[gi+1];
            end

            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_cmd         (cmd),
                .i_valid       (slot_valid),
                .i_link        (links[gi]),
                .o_link        (links[gi+1]),
                .i_left_entry  (left_entry),
                .i_right_entry (right_entry),
                .o_entry       (entries[gi]),
                .o_next_entry  (nexts[gi])
            );
        end
    endgenerate

    // Advance the count on a successful insert, drop it on a successful delete.
    always_comb begin
        n_count = r_count;
        if (cmd.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (cmd.del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Build the result from the post-operation state; head is zero when empty.
    always_comb begin
        n_out.status      = status;
        n_out.entry_count = COUNT_W'(n_count);
        n_out.head_valid  = (n_count != '0);
        n_out.head_value  = (n_count != '0) ? nexts[0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result payload until the output transfer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

### rtl/core/spq_cell.sv
// One storage cell of the sorted chain: holds one entry and shifts it.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire         i_clk,
    input  t_spq_cmd    i_cmd,
    input  wire         i_valid,
    input  t_spq_link   i_link,
    output t_spq_link   o_link,
    input  t_spq_value  i_left_entry,
    input  t_spq_value  i_right_entry,
    output t_spq_value  o_entry,
    output t_spq_value  o_next_entry
);

    t_spq_value r_entry;
    t_spq_value n_entry;
    logic       own_hit;
    logic       own_match;

    // Empty slots take any insert; stored entries take it when value >= entry.
    assign own_hit   = !i_valid || (i_cmd.value >= r_entry);
    assign own_match = i_valid && (i_cmd.value == r_entry);

    assign o_link.hit   = i_link.hit | own_hit;
    assign o_link.found = i_link.found | own_match;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (i_link.hit) begin
                n_entry = i_left_entry;
            end else if (own_hit) begin
                n_entry = i_cmd.value;
            end
        end else if (i_cmd.del) begin
            if (o_link.found) begin
                n_entry = i_right_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry      = r_entry;
    assign o_next_entry = n_entry;

endmodule

`default_nettype wire
